@@ hdl/embedding_gradient_scatter_add_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the gradient scatter-add block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EMBEDDING_GRADIENT_SCATTER_ADD_MACROS_SVH
`define EMBEDDING_GRADIENT_SCATTER_ADD_MACROS_SVH

// same-cycle implication
`define EGSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("egsa assertion failed");

// next-cycle implication
`define EGSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("egsa assertion failed");

`endif

@@ hdl/egsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egsa_pkg
// Shared widths, codes and register map of the gradient scatter-add block.
// ----------------------------------------------------------------------------
package egsa_pkg;

  localparam int GRAD_W   = 32;
  localparam int KIND_W   = 2;
  localparam int ROW_FW   = 10;
  localparam int POS_FW   = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCUM = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_SCALE = '0;

  localparam logic signed [GRAD_W-1:0] SCALE_RESET = 32'sd65536;
  localparam logic signed [GRAD_W-1:0] GRAD_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [GRAD_W-1:0] GRAD_MIN    = 32'sh8000_0000;

endpackage

@@ hdl/egsa_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egsa_in_if / egsa_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface egsa_in_if import egsa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [ROW_FW-1:0]        token_row;
  logic [POS_FW-1:0]        element_position;
  logic signed [GRAD_W-1:0] gradient_value;
  logic                     last_of_batch;

  modport source (output valid, kind, token_row, element_position, gradient_value,
                  last_of_batch, input ready);
  modport sink   (input valid, kind, token_row, element_position, gradient_value,
                  last_of_batch, output ready);
endinterface

interface egsa_out_if import egsa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] entry_value;
  logic                     saturated;
  logic                     batch_done;

  modport source (output valid, entry_value, saturated, batch_done, input ready);
  modport sink   (input valid, entry_value, saturated, batch_done, output ready);
endinterface

@@ hdl/egsa_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egsa_cfg
// APB register file holding the gradient scale.
// ----------------------------------------------------------------------------
module egsa_cfg import egsa_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [GRAD_W-1:0]            pwdata,
  output logic [GRAD_W-1:0]            prdata,
  output logic                         pready,
  output logic signed [GRAD_W-1:0]     scale
);

  logic signed [GRAD_W-1:0] scale_r;
  logic [CFG_IDX_W-1:0]     reg_idx;
  logic                     wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (wr_en && reg_idx == REG_GRADIENT_SCALE) begin
      scale_r <= pwdata;
    end
  end

  assign prdata = (reg_idx == REG_GRADIENT_SCALE) ? scale_r : '0;
  assign scale  = scale_r;

endmodule

@@ hdl/egsa_table_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egsa_table_mem
// Gradient table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module egsa_table_mem import egsa_pkg::*; #(
  parameter int DEPTH = 65536
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [$clog2(DEPTH)-1:0]           waddr,
  input  logic [GRAD_W-1:0]                  wdata,
  input  logic                               re,
  input  logic [$clog2(DEPTH)-1:0]           raddr,
  output logic [GRAD_W-1:0]                  rdata
);

  logic [GRAD_W-1:0] store_r [DEPTH];
  logic [GRAD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= store_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/embedding_gradient_scatter_add.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// embedding_gradient_scatter_add
// Gradient table scatter-add: accumulate, read and clear over one RAM.
// Accumulate/read: ST_LOOKUP reads the table and forms the product, then ST_UPDATE
//   adds, saturates and writes accumulates back to the same RAM, holding while the result slot is full.
// Clear: zeroes all VOCAB_ROWS*ROW_LEN entries, one entry zeroed per cycle, then
//   ST_CLR_DONE returns a zero result beat.
// Reset: sweeps the table to zero, accepting no beat during the sweep;
//   register writes are accepted.
// ----------------------------------------------------------------------------
`include "embedding_gradient_scatter_add_macros.svh"

module embedding_gradient_scatter_add import egsa_pkg::*; #(
  parameter int VOCAB_ROWS = 1024,
  parameter int ROW_LEN    = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  egsa_in_if.sink               in_beat,
  egsa_out_if.source            out_beat,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [GRAD_W-1:0]     pwdata,
  output logic [GRAD_W-1:0]     prdata,
  output logic                  pready
);

  localparam int DEPTH  = VOCAB_ROWS * ROW_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_CLR_DONE,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  state_t                   state_r;
  logic [ADDR_W-1:0]        clr_addr_r;
  logic                     clr_result_r;
  logic [ADDR_W-1:0]        addr_r;
  logic                     in_range_r;
  logic [KIND_W-1:0]        kind_r;
  logic signed [GRAD_W-1:0] val_r;
  logic                     last_r;
  logic signed [63:0]       prod_r;
  logic                     out_valid_r;
  logic signed [GRAD_W-1:0] out_entry_r;
  logic                     out_sat_r;
  logic                     out_done_r;

  logic signed [GRAD_W-1:0] scale;
  logic                     in_fire;
  logic                     slot_free;
  logic                     emit;
  logic                     out_load;
  logic                     do_accum;
  logic [ADDR_W-1:0]        in_addr;
  logic                     in_range;

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [GRAD_W-1:0]        mem_wdata;
  logic                     mem_re;
  logic [GRAD_W-1:0]        mem_rdata;

  logic signed [63:0]       acc64;
  logic                     fits;
  logic signed [GRAD_W-1:0] sat_val;
  logic signed [GRAD_W-1:0] res_entry;
  logic                     res_sat;
  logic                     res_done;

  egsa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .scale   (scale)
  );

  egsa_table_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  assign in_beat.ready = (state_r == ST_IDLE);
  assign in_fire       = in_beat.valid && in_beat.ready;
  assign slot_free     = !out_valid_r || out_beat.ready;
  assign in_range      = (int'(in_beat.token_row) < VOCAB_ROWS) &&
                         (int'(in_beat.element_position) < ROW_LEN);
  assign in_addr       = ADDR_W'(int'(in_beat.token_row) * ROW_LEN +
                                 int'(in_beat.element_position));

  // round half up folded into the add: entry * 2^16 + 2^15 + product
  assign acc64   = prod_r + {{16{mem_rdata[GRAD_W-1]}}, mem_rdata, 16'h8000};
  assign fits    = (&acc64[63:47]) || !(|acc64[63:47]);
  assign sat_val = fits ? acc64[47:16] : (acc64[63] ? GRAD_MIN : GRAD_MAX);

  assign do_accum = (kind_r == KIND_ACCUM) && in_range_r;
  assign emit     = (state_r == ST_UPDATE) && slot_free;
  assign out_load = slot_free && ((state_r == ST_UPDATE) || (state_r == ST_CLR_DONE));

  always_comb begin
    res_entry = '0;
    res_sat   = 1'b0;
    res_done  = 1'b0;
    if (kind_r == KIND_ACCUM) begin
      res_done = last_r;
      if (in_range_r) begin
        res_entry = sat_val;
        res_sat   = !fits;
      end
    end else if (kind_r == KIND_READ && in_range_r) begin
      res_entry = mem_rdata;
    end
  end

  assign mem_re    = (state_r == ST_LOOKUP);
  assign mem_we    = (state_r == ST_CLEAR) || (emit && do_accum);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r : addr_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : sat_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      clr_result_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_beat.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == LAST_ADDR) begin
            state_r <= clr_result_r ? ST_CLR_DONE : ST_IDLE;
          end
        end
        ST_CLR_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_entry_r <= '0;
            out_sat_r   <= 1'b0;
            out_done_r  <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            if (in_beat.kind == KIND_CLEAR) begin
              clr_addr_r   <= '0;
              clr_result_r <= 1'b1;
              state_r      <= ST_CLEAR;
            end else begin
              addr_r     <= in_addr;
              in_range_r <= in_range;
              kind_r     <= in_beat.kind;
              val_r      <= in_beat.gradient_value;
              last_r     <= in_beat.last_of_batch;
              state_r    <= ST_LOOKUP;
            end
          end
        end
        ST_LOOKUP: begin
          prod_r  <= 64'(scale) * 64'(val_r);
          state_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_entry_r <= res_entry;
            out_sat_r   <= res_sat;
            out_done_r  <= res_done;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_beat.valid       = out_valid_r;
  assign out_beat.entry_value = out_entry_r;
  assign out_beat.saturated   = out_sat_r;
  assign out_beat.batch_done  = out_done_r;

  `EGSA_ASSERT_NEXT(a_wb_matches_result, emit && do_accum, out_valid_r && out_entry_r == $past(mem_wdata))
  `EGSA_ASSERT_NOW(a_clear_writes_zero, state_r == ST_CLEAR, mem_we && mem_wdata == '0)
  `EGSA_ASSERT_NEXT(a_accept_starts_work, in_fire, state_r == ST_LOOKUP || state_r == ST_CLEAR)
  `EGSA_ASSERT_NOW(a_sat_at_limit, out_valid_r && out_sat_r, out_entry_r == GRAD_MAX || out_entry_r == GRAD_MIN)

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gradient scatter-add table. A queue-fed driver
// sends accumulate, read, clear and unused-kind beats; a monitor predicts each
// result from a shadow copy of the table and checks it against the output
// beats in order. Phases vary the gradient scale and the idling on each side.
// ----------------------------------------------------------------------------
module tb_top;
  import egsa_pkg::*;

  localparam int VOCAB          = 1024;
  localparam int ROW_LEN        = 64;
  localparam int TABLE_ENTRIES  = VOCAB * ROW_LEN;
  localparam int PHASES         = 6;
  localparam int BEATS_PER_PHASE = 272;
  localparam int MAX_CLEARS     = 4;
  localparam int MAX_REPORTS    = 10;
  localparam int unsigned CYCLE_LIMIT =
    (MAX_CLEARS + 3) * TABLE_ENTRIES * 3 + (PHASES * BEATS_PER_PHASE + 40) * 200;

  localparam logic [KIND_W-1:0]    KIND_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = REG_GRADIENT_SCALE + 1'b1;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic [ROW_FW-1:0]        row;
    logic [POS_FW-1:0]        pos;
    logic signed [GRAD_W-1:0] grad;
    logic                     last;
  } grad_beat_t;

  typedef struct {
    logic signed [GRAD_W-1:0] entry;
    logic                     sat;
    logic                     done;
  } entry_result_t;

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [GRAD_W-1:0]     pwdata  = '0;
  wire  [GRAD_W-1:0]     prdata;
  wire                   pready;

  egsa_in_if  in_ch ();
  egsa_out_if out_ch ();

  embedding_gradient_scatter_add #(
    .VOCAB_ROWS (VOCAB),
    .ROW_LEN    (ROW_LEN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_ch),
    .out_beat (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  logic signed [GRAD_W-1:0] shadow_table [TABLE_ENTRIES];
  logic signed [GRAD_W-1:0] shadow_scale = SCALE_RESET;
  grad_beat_t               pending_beats [$];
  entry_result_t            expected_entries [$];
  int unsigned              send_idle_pct  = 0;
  int unsigned              recv_stall_pct = 0;
  int unsigned              mismatches     = 0;
  int unsigned              cycles         = 0;
  int unsigned              clears_left    = MAX_CLEARS;
  logic [ROW_FW-1:0]        hot_rows [4];
  logic [POS_FW-1:0]        hot_pos [4];

  initial begin
    foreach (shadow_table[i]) shadow_table[i] = '0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // scatter-add prediction: round half up to Q16.16, saturating add
  function automatic entry_result_t predict_entry(grad_beat_t b);
    entry_result_t     r;
    logic signed [63:0] prod;
    logic signed [63:0] sum;
    int                addr;
    r.entry = '0;
    r.sat   = 1'b0;
    r.done  = 1'b0;
    addr    = int'(b.row) * ROW_LEN + int'(b.pos);
    case (b.kind)
      KIND_ACCUM: begin
        r.done = b.last;
        prod   = shadow_scale * b.grad;
        sum    = shadow_table[addr] + ((prod + 64'sd32768) >>> 16);
        if (sum > GRAD_MAX) begin
          sum   = GRAD_MAX;
          r.sat = 1'b1;
        end else if (sum < GRAD_MIN) begin
          sum   = GRAD_MIN;
          r.sat = 1'b1;
        end
        shadow_table[addr] = sum[GRAD_W-1:0];
        r.entry            = sum[GRAD_W-1:0];
      end
      KIND_READ: r.entry = shadow_table[addr];
      KIND_CLEAR: begin
        foreach (shadow_table[i]) shadow_table[i] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // beat driver
  always @(posedge clk) begin
    grad_beat_t b;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        b = pending_beats.pop_front();
        in_ch.valid            <= 1'b1;
        in_ch.kind             <= b.kind;
        in_ch.token_row        <= b.row;
        in_ch.element_position <= b.pos;
        in_ch.gradient_value   <= b.grad;
        in_ch.last_of_batch    <= b.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    grad_beat_t    seen;
    entry_result_t got;
    entry_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.kind = in_ch.kind;
        seen.row  = in_ch.token_row;
        seen.pos  = in_ch.element_position;
        seen.grad = in_ch.gradient_value;
        seen.last = in_ch.last_of_batch;
        expected_entries.push_back(predict_entry(seen));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.entry = out_ch.entry_value;
        got.sat   = out_ch.saturated;
        got.done  = out_ch.batch_done;
        if (expected_entries.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result beat: entry %h sat %b done %b",
                     got.entry, got.sat, got.done);
        end else begin
          want = expected_entries.pop_front();
          if (got.entry !== want.entry || got.sat !== want.sat || got.done !== want.done) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result mismatch: exp entry %h sat %b done %b, got entry %h sat %b done %b",
                       want.entry, want.sat, want.done, got.entry, got.sat, got.done);
          end
        end
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [GRAD_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_GRADIENT_SCALE) shadow_scale = data;
    @(negedge clk);
  endtask

  task automatic check_scale_readback();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_GRADIENT_SCALE, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== shadow_scale) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("scale readback mismatch: exp %h got %h", shadow_scale, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_beat(logic [KIND_W-1:0] kind, logic [ROW_FW-1:0] row,
                           logic [POS_FW-1:0] pos, logic signed [GRAD_W-1:0] grad,
                           logic last);
    grad_beat_t b;
    b.kind = kind;
    b.row  = row;
    b.pos  = pos;
    b.grad = grad;
    b.last = last;
    pending_beats.push_back(b);
  endtask

  // wait until every queued beat is taken and every result is back
  task automatic drain();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_ch.valid || expected_entries.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [ROW_FW-1:0] pick_row();
    if ($urandom_range(99) < 60) return hot_rows[$urandom_range(3)];
    return ROW_FW'($urandom());
  endfunction

  function automatic logic [POS_FW-1:0] pick_pos();
    if ($urandom_range(99) < 60) return hot_pos[$urandom_range(3)];
    return POS_FW'($urandom());
  endfunction

  function automatic logic signed [GRAD_W-1:0] pick_grad();
    case ($urandom_range(9))
      0, 1, 2, 3: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      4, 5, 6:    return $urandom();
      7:          return GRAD_MAX;
      8:          return GRAD_MIN;
      default:    return $signed($urandom_range(2)) - 32'sd1;
    endcase
  endfunction

  // batches of accumulates on a few hot entries, with reads, noise and rare clears
  task automatic queue_random_beats(int unsigned count);
    int unsigned made;
    int unsigned batch_len;
    int unsigned roll;
    made = 0;
    hot_rows = '{'0, '1, ROW_FW'($urandom()), ROW_FW'($urandom())};
    hot_pos  = '{'0, '1, POS_FW'($urandom()), POS_FW'($urandom())};
    while (made < count) begin
      batch_len = $urandom_range(1, 12);
      for (int j = 0; j < batch_len; j++) begin
        roll = $urandom_range(999);
        if (roll < 3 && clears_left != 0) begin
          clears_left--;
          push_beat(KIND_CLEAR, ROW_FW'($urandom()), POS_FW'($urandom()), $urandom(),
                    1'($urandom()));
        end else if (roll < 30) begin
          push_beat(KIND_UNUSED, ROW_FW'($urandom()), POS_FW'($urandom()), $urandom(),
                    1'($urandom()));
        end else if (roll < 230) begin
          push_beat(KIND_READ, pick_row(), pick_pos(), $urandom(), 1'($urandom()));
        end else begin
          push_beat(KIND_ACCUM, pick_row(), pick_pos(), pick_grad(), j == batch_len - 1);
        end
        made++;
      end
    end
  endtask

  initial begin
    logic [GRAD_W-1:0] phase_scales [PHASES];
    int unsigned       send_modes [PHASES];
    int unsigned       recv_modes [PHASES];
    phase_scales = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000,
                     32'h0000_0003, $urandom()};
    send_modes   = '{0, 65, 0, 17, 0, 65};
    recv_modes   = '{0, 0, 65, 17, 0, 0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    check_scale_readback();
    cfg_write(REG_GRADIENT_SCALE, SCALE_RESET);
    cfg_write(REG_UNMAPPED, $urandom());
    check_scale_readback();

    // saturation at both rails, extreme rows and positions
    push_beat(KIND_ACCUM, '0, '0, GRAD_MAX, 1'b0);
    push_beat(KIND_ACCUM, '0, '0, 32'sd1, 1'b0);
    push_beat(KIND_READ, '0, '0, GRAD_MAX, 1'b1);
    push_beat(KIND_ACCUM, '1, '1, GRAD_MIN, 1'b1);
    push_beat(KIND_ACCUM, '1, '1, -32'sd1, 1'b0);
    push_beat(KIND_READ, '1, '1, '0, 1'b0);
    push_beat(KIND_UNUSED, '1, '1, '1, 1'b1);
    push_beat(KIND_CLEAR, '1, '1, '1, 1'b1);
    push_beat(KIND_READ, '0, '0, '0, 1'b0);
    push_beat(KIND_READ, '1, '1, '0, 1'b0);
    push_beat(KIND_ACCUM, '0, '0, '0, 1'b1);
    drain();

    // round-half-up at the smallest scale
    cfg_write(REG_GRADIENT_SCALE, 32'sd1);
    check_scale_readback();
    push_beat(KIND_ACCUM, 10'd2, 6'd3, 32'sh0000_8000, 1'b0);
    push_beat(KIND_ACCUM, 10'd2, 6'd3, 32'sh0000_7FFF, 1'b0);
    push_beat(KIND_ACCUM, 10'd2, 6'd3, -32'sh0000_8000, 1'b0);
    push_beat(KIND_ACCUM, 10'd2, 6'd3, -32'sh0000_8001, 1'b1);
    push_beat(KIND_READ, 10'd2, 6'd3, '0, 1'b1);
    push_beat(KIND_ACCUM, 10'd2, 6'd3, GRAD_MIN, 1'b0);
    push_beat(KIND_ACCUM, 10'd2, 6'd3, GRAD_MAX, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct  = send_modes[p];
      recv_stall_pct = recv_modes[p];
      cfg_write(REG_GRADIENT_SCALE, phase_scales[p]);
      check_scale_readback();
      queue_random_beats(BEATS_PER_PHASE / 2);
      drain();
      queue_random_beats(BEATS_PER_PHASE - BEATS_PER_PHASE / 2);
      drain();
    end

    if (mismatches == 0 && expected_entries.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
